### rtl/core/bfba_pkg.sv
package bfba_pkg;

   // Default table geometry.
   localparam int DEFAULT_NUM_BLOCKS = 16;
   localparam int DEFAULT_SIZE_BITS  = 16;

   // Fixed widths of the request and response fields.
   localparam int ENTRY_BITS       = 4;
   localparam int FIELD_SIZE_BITS  = 16;
   localparam int BLOCK_INDEX_BITS = 4;
   localparam int LEFTOVER_BITS    = 16;

   // Request operation codes.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // Control part of the search token that walks down the cell chain.
   typedef struct packed {
      logic valid;
      logic found;
   } tok_ctl_type;

endpackage

### rtl/core/bfba_req_if.sv
interface bfba_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic [bfba_pkg::ENTRY_BITS-1:0]      entry_index;
   logic [bfba_pkg::FIELD_SIZE_BITS-1:0] size_value;

   modport source (output valid, output op, output entry_index, output size_value,
                   input ready);
   modport sink   (input valid, input op, input entry_index, input size_value,
                   output ready);
endinterface

### rtl/core/bfba_rsp_if.sv
interface bfba_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  granted;
   logic [bfba_pkg::BLOCK_INDEX_BITS-1:0] block_index;
   logic [bfba_pkg::LEFTOVER_BITS-1:0]    leftover;

   modport source (output valid, output granted, output block_index, output leftover,
                   input ready);
   modport sink   (input valid, input granted, input block_index, input leftover,
                   output ready);
endinterface

### rtl/core/best_fit_block_allocator_core.sv
// Best-fit block allocator. The block keeps a table of NUM_BLOCKS entries, each
// with a block size and loaded/allocated marks. A load request (op = load) writes
// one entry's size and marks it loaded and free; it produces no response, and a
// load whose entry_index lies beyond the table is dropped. An allocation request
// finds the loaded, free block whose size is at least the requested size and
// leaves the least space, the lowest index winning a tie, marks it allocated and
// returns granted, block_index and leftover; when nothing fits the response is
// not granted with block_index and leftover zero. Each table entry lives in one
// cell of a chain, and a search token moves one cell per cycle; the result is
// captured from the last cell into a result register and then into the response
// register once the response channel is free. While an allocation is in flight
// no new request is accepted; a load may be accepted while an earlier response
// still waits on the response channel.
module best_fit_block_allocator_core #(
   parameter int NUM_BLOCKS = bfba_pkg::DEFAULT_NUM_BLOCKS,
   parameter int SIZE_BITS  = bfba_pkg::DEFAULT_SIZE_BITS
) (
   input logic        clock,
   input logic        reset,
   bfba_req_if.sink   req_if,
   bfba_rsp_if.source rsp_if
);

   localparam int IDX_BITS = $clog2(NUM_BLOCKS);

   // Controller states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_OUTPUT = 2'd2;

   logic [1:0] state_ff, state_in;

   // Requested size held to SIZE_BITS bits, whatever the field width.
   logic [31:0]          req_size_wide;
   logic [SIZE_BITS-1:0] req_size;

   logic req_fire;
   logic load_en;
   logic search_start;

   // Token chain: entry 0 is the launch point, entry i+1 the output of cell i.
   bfba_pkg::tok_ctl_type chain_ctl  [0:NUM_BLOCKS];
   logic [IDX_BITS-1:0]   chain_idx  [0:NUM_BLOCKS];
   logic [SIZE_BITS-1:0]  chain_left [0:NUM_BLOCKS];
   logic [SIZE_BITS-1:0]  chain_size [0:NUM_BLOCKS];

   // Search result captured from the end of the chain.
   logic                 res_found_ff, res_found_in;
   logic [IDX_BITS-1:0]  res_idx_ff, res_idx_in;
   logic [SIZE_BITS-1:0] res_left_ff, res_left_in;

   // Response output register.
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_granted_ff, rsp_granted_in;
   logic [bfba_pkg::BLOCK_INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [bfba_pkg::LEFTOVER_BITS-1:0]    rsp_left_ff, rsp_left_in;

   logic [31:0] res_idx_wide;
   logic [31:0] res_left_wide;
   logic        out_free;
   logic        alloc_en;

   assign req_size_wide = 32'(req_if.size_value);
   assign req_size      = req_size_wide[SIZE_BITS-1:0];

   // New requests are taken only when no allocation is in flight.
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign req_fire      = req_if.valid && req_if.ready;
   assign load_en       = req_fire && (req_if.op == bfba_pkg::OP_LOAD);
   assign search_start  = req_fire && (req_if.op == bfba_pkg::OP_REQUEST);

   // Launch a fresh token carrying the requested size and an empty best choice.
   assign chain_ctl[0].valid = search_start;
   assign chain_ctl[0].found = 1'b0;
   assign chain_idx[0]       = '0;
   assign chain_left[0]      = '0;
   assign chain_size[0]      = req_size;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_BLOCKS; gi++) begin : g_cell
         bfba_cell #(
            .CELL_INDEX (gi),
            .IDX_BITS   (IDX_BITS),
            .SIZE_BITS  (SIZE_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .load_en     (load_en),
            .load_index  (req_if.entry_index),
            .load_size   (req_size),
            .alloc_en    (alloc_en),
            .alloc_index (res_idx_ff),
            .in_ctl      (chain_ctl[gi]),
            .in_idx      (chain_idx[gi]),
            .in_left     (chain_left[gi]),
            .in_size     (chain_size[gi]),
            .out_ctl     (chain_ctl[gi+1]),
            .out_idx     (chain_idx[gi+1]),
            .out_left    (chain_left[gi+1]),
            .out_size    (chain_size[gi+1])
         );
      end
   endgenerate

   assign res_idx_wide  = 32'(res_idx_ff);
   assign res_left_wide = 32'(res_left_ff);
   assign out_free      = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in       = state_ff;
      res_found_in   = res_found_ff;
      res_idx_in     = res_idx_ff;
      res_left_in    = res_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_left_in    = rsp_left_ff;
      alloc_en       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (search_start) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // The token leaves the last cell holding the best fit of the whole table.
            if (chain_ctl[NUM_BLOCKS].valid) begin
               res_found_in = chain_ctl[NUM_BLOCKS].found;
               res_idx_in   = chain_idx[NUM_BLOCKS];
               res_left_in  = chain_left[NUM_BLOCKS];
               state_in     = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            // Present the response and claim the block in the same cycle, so the
            // next search already sees the entry as allocated.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_found_ff;
               rsp_index_in   = res_found_ff ?
                                res_idx_wide[bfba_pkg::BLOCK_INDEX_BITS-1:0] : '0;
               rsp_left_in    = res_found_ff ?
                                res_left_wide[bfba_pkg::LEFTOVER_BITS-1:0] : '0;
               alloc_en       = res_found_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_found_ff   <= res_found_in;
      res_idx_ff     <= res_idx_in;
      res_left_ff    <= res_left_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_left_ff    <= rsp_left_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.granted     = rsp_granted_ff;
   assign rsp_if.block_index = rsp_index_ff;
   assign rsp_if.leftover    = rsp_left_ff;

endmodule

### rtl/core/bfba_cell.sv
// One table entry plus one stage of the search token pipeline.
module bfba_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_BITS   = 4,
   parameter int SIZE_BITS  = bfba_pkg::DEFAULT_SIZE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load_en,
   input  logic [bfba_pkg::ENTRY_BITS-1:0]   load_index,
   input  logic [SIZE_BITS-1:0]              load_size,
   input  logic                              alloc_en,
   input  logic [IDX_BITS-1:0]               alloc_index,
   input  bfba_pkg::tok_ctl_type             in_ctl,
   input  logic [IDX_BITS-1:0]               in_idx,
   input  logic [SIZE_BITS-1:0]              in_left,
   input  logic [SIZE_BITS-1:0]              in_size,
   output bfba_pkg::tok_ctl_type             out_ctl,
   output logic [IDX_BITS-1:0]               out_idx,
   output logic [SIZE_BITS-1:0]              out_left,
   output logic [SIZE_BITS-1:0]              out_size
);

   logic [SIZE_BITS-1:0]  size_ff;
   logic                  loaded_ff;
   logic                  alloc_ff;
   bfba_pkg::tok_ctl_type ctl_ff, ctl_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [SIZE_BITS-1:0]  left_ff, left_in;
   logic [SIZE_BITS-1:0]  reqsz_ff;

   logic                  load_hit;
   logic                  alloc_hit;
   logic                  fits;
   logic                  take;
   logic [SIZE_BITS-1:0]  left;

   assign load_hit  = load_en && (32'(load_index) == 32'(CELL_INDEX));
   assign alloc_hit = alloc_en && (alloc_index == IDX_BITS'(CELL_INDEX));

   assign fits = loaded_ff && !alloc_ff && (size_ff >= in_size);
   assign left = size_ff - in_size;
   assign take = in_ctl.valid && fits && (!in_ctl.found || (left < in_left));

   always_comb begin
      ctl_in.valid = in_ctl.valid;
      ctl_in.found = in_ctl.found || take;
      idx_in       = take ? IDX_BITS'(CELL_INDEX) : in_idx;
      left_in      = take ? left : in_left;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         alloc_ff  <= 1'b0;
         ctl_ff    <= '0;
      end else begin
         ctl_ff <= ctl_in;
         if (load_hit) begin
            loaded_ff <= 1'b1;
            alloc_ff  <= 1'b0;
         end else if (alloc_hit) begin
            alloc_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         size_ff <= load_size;
      end
      idx_ff   <= idx_in;
      left_ff  <= left_in;
      reqsz_ff <= in_size;
   end

   assign out_ctl  = ctl_ff;
   assign out_idx  = idx_ff;
   assign out_left = left_ff;
   assign out_size = reqsz_ff;

endmodule

### rtl/core/bfba_checker.sv
module bfba_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_op,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_granted,
   input logic [bfba_pkg::BLOCK_INDEX_BITS-1:0] rsp_block_index,
   input logic [bfba_pkg::LEFTOVER_BITS-1:0]    rsp_leftover
);

   // No response is pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_granted) &&
                                     $stable(rsp_block_index) && $stable(rsp_leftover)))
      else $error("stalled response changed");

   // A refused allocation reports a zero index and zero leftover.
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> (rsp_block_index == '0 && rsp_leftover == '0))
      else $error("refused allocation with nonzero fields");

   // An accepted allocation keeps the request channel closed while it searches.
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == bfba_pkg::OP_REQUEST) |=> !req_ready)
      else $error("request accepted during a search");

   // A load never produces a response of its own.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == bfba_pkg::OP_LOAD && !rsp_valid) |=> !rsp_valid)
      else $error("load produced a response");

endmodule

bind best_fit_block_allocator_core bfba_checker u_bfba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_op          (req_if.op),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_granted     (rsp_if.granted),
   .rsp_block_index (rsp_if.block_index),
   .rsp_leftover    (rsp_if.leftover)
);
